// ----- rtl/ebr_pkg.sv -----
// Shared types for the ellipse raster core: default sizes, the command and
// status bundles that pass between the controller and the datapath.
// No dependencies.
`default_nettype none

package ebr_pkg;

  // Default field sizes.
  localparam int unsigned COORD_BITS_DEF  = 12;
  localparam int unsigned RADIUS_BITS_DEF = 10;

  // Operand pair that the shared multiplier works on in a cycle.
  typedef enum logic [3:0] {
    M_NONE,    // no product needed
    M_AA,      // a * a
    M_BB,      // b * b
    M_A4,      // aa * aa
    M_DINIT1,  // aa * (1 - 2b)
    M_DINIT2,  // bb * (1 - 2a)
    M_XX,      // x * x
    M_PXS,     // previous product * (aa + bb)
    M_AAS,     // aa * (aa + bb)
    M_INC1,    // bb * (4x + 6)
    M_COR1,    // aa * (4 - 4y)
    M_INC2,    // aa * (4y + 6)
    M_COR2     // bb * (4 - 4x)
  } mul_sel_e;

  // Register update that the datapath performs in a cycle.
  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,        // latch centre and radii, offset to (0, b)
    A_WR_AA,       // store a * a
    A_WR_BB,       // store b * b
    A_WR_A4,       // store a^4 and aa + bb
    A_DEC_SET_BB,  // decision = product + bb
    A_DEC_SET_AA,  // decision = product + aa
    A_TEST,        // region test: product <= a^4
    A_ADD_INC,     // note decision sign, add the increment
    A_R1_FIN,      // region one correction, x up, maybe y down
    A_R2_INIT,     // offset to (a, 0)
    A_R2_FIN,      // region two correction, y up, maybe x down
    A_EMIT         // load the output register
  } act_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    act_e     act;
    logic     emit_ok;
    logic     emit_last;
  } cmd_t;

  typedef struct packed {
    logic below;      // last region test passed
    logic both_zero;  // both radii are zero
    logic out_free;   // output register can take an item this cycle
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/ebr_datapath.sv -----
// Datapath of the ellipse raster core: held ellipse, offsets, decision,
// shared multiplier and the output register. Uses ebr_pkg.
`default_nettype none

module ebr_datapath #(
  parameter int unsigned COORD_BITS  = ebr_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = ebr_pkg::RADIUS_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ebr_pkg::cmd_t                     cmd_i,
  output ebr_pkg::sts_t                     sts_o,
  input  logic signed [COORD_BITS-1:0]      center_x_i,
  input  logic signed [COORD_BITS-1:0]      center_y_i,
  input  logic        [RADIUS_BITS-1:0]     radius_x_i,
  input  logic        [RADIUS_BITS-1:0]     radius_y_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic        [8*(COORD_BITS+1)-1:0] out_data_o,
  output logic                              out_points_valid_o,
  output logic                              out_last_o
);
  import ebr_pkg::*;

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned R   = RADIUS_BITS;
  localparam int unsigned XW  = R + 1;             // x offset, 0 .. a + 1
  localparam int unsigned YW  = R + 2;             // y offset, signed
  localparam int unsigned MW  = 2 * R + 2;         // multiplier operand
  localparam int unsigned PW  = 2 * MW;            // product and decision
  localparam int unsigned PTW = C + 1;             // point coordinate
  localparam int unsigned SW  = ((C > YW) ? C : YW) + 1;

  localparam logic signed [MW-1:0] M_ONE  = MW'(1);
  localparam logic signed [MW-1:0] M_FOUR = MW'(4);
  localparam logic signed [MW-1:0] M_SIX  = MW'(6);
  localparam logic        [XW-1:0] X_ONE  = XW'(1);
  localparam logic signed [YW-1:0] Y_ONE  = YW'(1);

  logic signed [C-1:0]   cx_q, cy_q;
  logic        [R-1:0]   a_q, b_q;
  logic        [XW-1:0]  x_q;
  logic signed [YW-1:0]  y_q;
  logic signed [PW-1:0]  dec_q;
  logic        [2*R-1:0] aa_q, bb_q;
  logic        [2*R:0]   s_q;
  logic        [4*R-1:0] a4_q;
  logic signed [PW-1:0]  prod_q;
  logic                  below_q;
  logic                  neg_q;

  logic signed [MW-1:0]  a_e, b_e, x_e, y_e, aa_e, bb_e, s_e, pp_e;
  logic signed [MW-1:0]  op_a, op_b;
  logic signed [PW-1:0]  mul_res;
  logic signed [PW-1:0]  aa_w, bb_w, a4_w;

  logic signed [SW-1:0]  cx_w, cy_w, xo_w, yo_w;
  logic signed [SW-1:0]  sum_xp, sum_xm, sum_yp, sum_ym;
  logic        [8*PTW-1:0] pts;

  logic                  out_valid_q;
  logic                  out_pv_q;
  logic                  out_last_q;
  logic        [8*PTW-1:0] out_data_q;

  // Operands widened to the multiplier width.
  always_comb begin
    a_e  = {{(MW-R){1'b0}}, a_q};
    b_e  = {{(MW-R){1'b0}}, b_q};
    x_e  = {{(MW-XW){1'b0}}, x_q};
    y_e  = {{(MW-YW){y_q[YW-1]}}, y_q};
    aa_e = {{(MW-2*R){1'b0}}, aa_q};
    bb_e = {{(MW-2*R){1'b0}}, bb_q};
    s_e  = {{(MW-2*R-1){1'b0}}, s_q};
    pp_e = prod_q[MW-1:0];
    aa_w = {{(PW-2*R){1'b0}}, aa_q};
    bb_w = {{(PW-2*R){1'b0}}, bb_q};
    a4_w = {{(PW-4*R){1'b0}}, a4_q};
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_sel)
      M_AA: begin
        op_a = a_e;
        op_b = a_e;
      end
      M_BB: begin
        op_a = b_e;
        op_b = b_e;
      end
      M_A4: begin
        op_a = aa_e;
        op_b = aa_e;
      end
      M_DINIT1: begin
        op_a = aa_e;
        op_b = M_ONE - (b_e <<< 1);
      end
      M_DINIT2: begin
        op_a = bb_e;
        op_b = M_ONE - (a_e <<< 1);
      end
      M_XX: begin
        op_a = x_e;
        op_b = x_e;
      end
      M_PXS: begin
        op_a = pp_e;
        op_b = s_e;
      end
      M_AAS: begin
        op_a = aa_e;
        op_b = s_e;
      end
      M_INC1: begin
        op_a = bb_e;
        op_b = (x_e <<< 2) + M_SIX;
      end
      M_COR1: begin
        op_a = aa_e;
        op_b = M_FOUR - (y_e <<< 2);
      end
      M_INC2: begin
        op_a = aa_e;
        op_b = (y_e <<< 2) + M_SIX;
      end
      M_COR2: begin
        op_a = bb_e;
        op_b = M_FOUR - (x_e <<< 2);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_res = op_a * op_b;

  // Product register and the working state of the ellipse.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_res;
    case (cmd_i.act)
      A_LOAD: begin
        cx_q <= center_x_i;
        cy_q <= center_y_i;
        a_q  <= radius_x_i;
        b_q  <= radius_y_i;
        x_q  <= '0;
        y_q  <= {2'b00, radius_y_i};
      end
      A_WR_AA: aa_q <= prod_q[2*R-1:0];
      A_WR_BB: bb_q <= prod_q[2*R-1:0];
      A_WR_A4: begin
        a4_q <= prod_q[4*R-1:0];
        s_q  <= {1'b0, aa_q} + {1'b0, bb_q};
      end
      A_DEC_SET_BB: dec_q <= prod_q + bb_w;
      A_DEC_SET_AA: dec_q <= prod_q + aa_w;
      A_TEST:       below_q <= (prod_q <= a4_w);
      A_ADD_INC: begin
        neg_q <= dec_q[PW-1];
        dec_q <= dec_q + prod_q;
      end
      A_R1_FIN: begin
        if (!neg_q) begin
          dec_q <= dec_q + prod_q;
          y_q   <= y_q - Y_ONE;
        end
        x_q <= x_q + X_ONE;
      end
      A_R2_INIT: begin
        x_q <= {1'b0, a_q};
        y_q <= '0;
      end
      A_R2_FIN: begin
        if (!neg_q) begin
          dec_q <= dec_q + prod_q;
          x_q   <= x_q - X_ONE;
        end
        y_q <= y_q + Y_ONE;
      end
      default: ;
    endcase
  end

  // The four symmetric points, wrapped to the coordinate width.
  always_comb begin
    cx_w   = SW'(cx_q);
    cy_w   = SW'(cy_q);
    xo_w   = {{(SW-XW){1'b0}}, x_q};
    yo_w   = {{(SW-YW){y_q[YW-1]}}, y_q};
    sum_xp = cx_w + xo_w;
    sum_xm = cx_w - xo_w;
    sum_yp = cy_w + yo_w;
    sum_ym = cy_w - yo_w;
    pts = {sum_yp[PTW-1:0], sum_xm[PTW-1:0],
           sum_ym[PTW-1:0], sum_xm[PTW-1:0],
           sum_ym[PTW-1:0], sum_xp[PTW-1:0],
           sum_yp[PTW-1:0], sum_xp[PTW-1:0]};
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.act == A_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload; an ignored step gives all zeros.
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == A_EMIT) begin
      out_data_q <= cmd_i.emit_ok ? pts : '0;
      out_pv_q   <= cmd_i.emit_ok;
      out_last_q <= cmd_i.emit_ok & cmd_i.emit_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_data_q;
  assign out_points_valid_o = out_pv_q;
  assign out_last_o         = out_last_q;

  assign sts_o.below     = below_q;
  assign sts_o.both_zero = (a_q == '0) && (b_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // An item without points carries no coordinates.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_pv_q) |-> (out_data_q == '0))
    else $error("point-less item has nonzero coordinates");

  // The final point set is always a real one.
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> out_pv_q)
    else $error("last flag on an item without points");

endmodule

`default_nettype wire

// ----- rtl/ebr_ctrl.sv -----
// Controller of the ellipse raster core: drawing phase and the cycle
// sequence that drives the datapath for each item. Uses ebr_pkg.
`default_nettype none

module ebr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_kind_i,
  output logic          in_ready_o,
  input  ebr_pkg::sts_t sts_i,
  output ebr_pkg::cmd_t cmd_o
);
  import ebr_pkg::*;

  // Drawing phase.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_REG1 = 2'd1;
  localparam logic [1:0] PH_REG2 = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Sequencer states.
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_S_AA   = 5'd1;
  localparam logic [4:0] ST_S_BB   = 5'd2;
  localparam logic [4:0] ST_S_A4   = 5'd3;
  localparam logic [4:0] ST_S_DI   = 5'd4;
  localparam logic [4:0] ST_S_DS   = 5'd5;
  localparam logic [4:0] ST_R1_XX  = 5'd6;
  localparam logic [4:0] ST_R1_XS  = 5'd7;
  localparam logic [4:0] ST_R1_TST = 5'd8;
  localparam logic [4:0] ST_R1_BR  = 5'd9;
  localparam logic [4:0] ST_R1_FIN = 5'd10;
  localparam logic [4:0] ST_R1_SWD = 5'd11;
  localparam logic [4:0] ST_R1_SWT = 5'd12;
  localparam logic [4:0] ST_R1_SWE = 5'd13;
  localparam logic [4:0] ST_R2_INC = 5'd14;
  localparam logic [4:0] ST_R2_COR = 5'd15;
  localparam logic [4:0] ST_R2_FIN = 5'd16;
  localparam logic [4:0] ST_R2_XX  = 5'd17;
  localparam logic [4:0] ST_R2_XS  = 5'd18;
  localparam logic [4:0] ST_R2_TST = 5'd19;
  localparam logic [4:0] ST_R2_END = 5'd20;
  localparam logic [4:0] ST_EMIT   = 5'd21;

  logic [4:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       emit_ok_q, emit_ok_d;
  logic       emit_last_q, emit_last_d;
  logic       in_acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    emit_ok_d     = emit_ok_q;
    emit_last_d   = emit_last_q;
    cmd_o.mul_sel = M_NONE;
    cmd_o.act     = A_NONE;
    cmd_o.emit_ok   = emit_ok_q;
    cmd_o.emit_last = emit_last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_kind_i) begin
            cmd_o.act = A_LOAD;
            state_d   = ST_S_AA;
          end else begin
            case (phase_q)
              PH_REG1: state_d = ST_R1_XX;
              PH_REG2: state_d = ST_R2_INC;
              default: begin
                emit_ok_d   = 1'b0;
                emit_last_d = 1'b0;
                state_d     = ST_EMIT;
              end
            endcase
          end
        end
      end
      // Per-ellipse products and the starting decision.
      ST_S_AA: begin
        cmd_o.mul_sel = M_AA;
        state_d       = ST_S_BB;
      end
      ST_S_BB: begin
        cmd_o.act     = A_WR_AA;
        cmd_o.mul_sel = M_BB;
        state_d       = ST_S_A4;
      end
      ST_S_A4: begin
        cmd_o.act     = A_WR_BB;
        cmd_o.mul_sel = M_A4;
        state_d       = ST_S_DI;
      end
      ST_S_DI: begin
        cmd_o.act     = A_WR_A4;
        cmd_o.mul_sel = M_DINIT1;
        state_d       = ST_S_DS;
      end
      ST_S_DS: begin
        cmd_o.act   = A_DEC_SET_BB;
        emit_ok_d   = 1'b1;
        emit_last_d = sts_i.both_zero;
        phase_d     = sts_i.both_zero ? PH_DONE : PH_REG1;
        state_d     = ST_EMIT;
      end
      // Region one: test x, then step the decision.
      ST_R1_XX: begin
        cmd_o.mul_sel = M_XX;
        state_d       = ST_R1_XS;
      end
      ST_R1_XS: begin
        cmd_o.mul_sel = M_PXS;
        state_d       = ST_R1_TST;
      end
      ST_R1_TST: begin
        cmd_o.act     = A_TEST;
        cmd_o.mul_sel = M_INC1;
        state_d       = ST_R1_BR;
      end
      ST_R1_BR: begin
        if (sts_i.below) begin
          cmd_o.act     = A_ADD_INC;
          cmd_o.mul_sel = M_COR1;
          state_d       = ST_R1_FIN;
        end else begin
          cmd_o.act     = A_R2_INIT;
          cmd_o.mul_sel = M_DINIT2;
          state_d       = ST_R1_SWD;
        end
      end
      ST_R1_FIN: begin
        cmd_o.act   = A_R1_FIN;
        emit_ok_d   = 1'b1;
        emit_last_d = 1'b0;
        state_d     = ST_EMIT;
      end
      // Switch to region two at (a, 0).
      ST_R1_SWD: begin
        cmd_o.act     = A_DEC_SET_AA;
        cmd_o.mul_sel = M_AAS;
        state_d       = ST_R1_SWT;
      end
      ST_R1_SWT: begin
        cmd_o.act = A_TEST;
        state_d   = ST_R1_SWE;
      end
      ST_R1_SWE: begin
        emit_ok_d   = 1'b1;
        emit_last_d = sts_i.below;
        phase_d     = sts_i.below ? PH_DONE : PH_REG2;
        state_d     = ST_EMIT;
      end
      // Region two: step the decision, then test the new x.
      ST_R2_INC: begin
        cmd_o.mul_sel = M_INC2;
        state_d       = ST_R2_COR;
      end
      ST_R2_COR: begin
        cmd_o.act     = A_ADD_INC;
        cmd_o.mul_sel = M_COR2;
        state_d       = ST_R2_FIN;
      end
      ST_R2_FIN: begin
        cmd_o.act = A_R2_FIN;
        state_d   = ST_R2_XX;
      end
      ST_R2_XX: begin
        cmd_o.mul_sel = M_XX;
        state_d       = ST_R2_XS;
      end
      ST_R2_XS: begin
        cmd_o.mul_sel = M_PXS;
        state_d       = ST_R2_TST;
      end
      ST_R2_TST: begin
        cmd_o.act = A_TEST;
        state_d   = ST_R2_END;
      end
      ST_R2_END: begin
        emit_ok_d   = 1'b1;
        emit_last_d = sts_i.below;
        if (sts_i.below) begin
          phase_d = PH_DONE;
        end
        state_d = ST_EMIT;
      end
      // Hand the result to the output register once it has room.
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.act = A_EMIT;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      emit_ok_q   <= 1'b0;
      emit_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      emit_ok_q   <= emit_ok_d;
      emit_last_q <= emit_last_d;
    end
  end

  // The output register is never overwritten while it still holds an item.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.act == A_EMIT) |-> sts_i.out_free)
    else $error("emit while output register is occupied");

  // A step with nothing to draw goes straight to an empty result.
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_kind_i && (phase_q == PH_IDLE || phase_q == PH_DONE))
    |=> (state_q == ST_EMIT && !emit_ok_q))
    else $error("step without an ellipse did not give an empty result");

  // A start always ends in region one or, for zero radii, in done.
  a_start_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_S_DS)
    |=> (state_q == ST_EMIT && emit_ok_q && (phase_q == PH_REG1 || phase_q == PH_DONE)))
    else $error("start did not enter region one or done");

endmodule

`default_nettype wire

// ----- rtl/ellipse_bresenham_raster_core.sv -----
// Items are taken one at a time: the next item is accepted only after the result
// of the last has been loaded into the output register, which waits for room
// when the receiver stalls. A step with nothing to draw goes straight to its
// result; the single shared multiplier paces the sequence for all other items.
// Reset is asynchronous and active low; it clears the phase, the sequencer and
// the output valid flag at once, with no clearing pass.
`default_nettype none

module ellipse_bresenham_raster_core #(
  parameter int unsigned COORD_BITS  = ebr_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = ebr_pkg::RADIUS_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // center_x, center_y, radius_x, radius_y, zero fill
  input  logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] s_axis_tdata,
  // kind
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y
  output logic [8*(COORD_BITS+1)-1:0] m_axis_tdata,
  // points_valid
  output logic m_axis_tuser,
  output logic m_axis_tlast
);
  import ebr_pkg::*;

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned R = RADIUS_BITS;

  cmd_t cmd;
  sts_t sts;

  logic signed [C-1:0] center_x, center_y;
  logic        [R-1:0] radius_x, radius_y;

  // Input item fields.
  assign center_x = s_axis_tdata[C-1:0];
  assign center_y = s_axis_tdata[2*C-1:C];
  assign radius_x = s_axis_tdata[2*C+R-1:2*C];
  assign radius_y = s_axis_tdata[2*C+2*R-1:2*C+R];

  ebr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ebr_datapath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .center_x_i         (center_x),
    .center_y_i         (center_y),
    .radius_x_i         (radius_x),
    .radius_y_i         (radius_y),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .out_data_o         (m_axis_tdata),
    .out_points_valid_o (m_axis_tuser),
    .out_last_o         (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ellipse_bresenham_raster_core: drives start and
// step items on the input stream and checks every point set that comes out.
// Depends on ebr_pkg and the core RTL only.

module tb;

  localparam int CW    = ebr_pkg::COORD_BITS_DEF;
  localparam int RW    = ebr_pkg::RADIUS_BITS_DEF;
  localparam int CW1   = CW + 1;
  localparam int DW    = ((2 * CW + 2 * RW + 7) / 8) * 8;
  localparam int OUT_W = 8 * CW1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 1000;

  typedef enum logic {KIND_START = 1'b0, KIND_STEP = 1'b1} item_kind_e;
  typedef enum logic [1:0] {DRAW_IDLE, DRAW_REGION1, DRAW_REGION2, DRAW_DONE} draw_phase_e;

  typedef struct packed {
    logic             last;
    logic             valid;
    logic [OUT_W-1:0] coords;
  } point_set_t;

  // Tracks the rasterizer state and holds the point sets still owed by the core.
  class ellipse_tracker;
    draw_phase_e phase;
    longint off_x, off_y, dec, cx, cy, ra, rb;
    point_set_t pending_sets[$];
    int accepted, starts, checked, completed, empties, errors;

    function new();
      phase = DRAW_IDLE;
      off_x = 0; off_y = 0; dec = 0; cx = 0; cy = 0; ra = 0; rb = 0;
      accepted = 0; starts = 0; checked = 0; completed = 0; empties = 0; errors = 0;
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("tb: mismatch %0d: %s", errors, what);
    endfunction

    // Region one holds while x*x*(a*a+b*b) <= a^4, in exact integers.
    function bit under_bound(longint x);
      longint unsigned ux = x;
      longint unsigned a2 = ra * ra;
      longint unsigned b2 = rb * rb;
      return ux * ux * (a2 + b2) <= a2 * a2;
    endfunction

    function point_set_t make_point_set(bit ok, bit fin);
      point_set_t ps;
      longint c[8];
      ps = '0;
      if (ok) begin
        c[0] = cx + off_x; c[1] = cy + off_y;
        c[2] = cx + off_x; c[3] = cy - off_y;
        c[4] = cx - off_x; c[5] = cy - off_y;
        c[6] = cx - off_x; c[7] = cy + off_y;
        for (int i = 0; i < 8; i++) ps.coords[i*CW1 +: CW1] = c[i][CW1-1:0];
        ps.valid = 1'b1;
        ps.last  = fin;
      end
      return ps;
    endfunction

    // Advances the tracked state by one item and returns the point set it yields.
    function point_set_t predict_point_set(logic kind, logic [DW-1:0] data);
      logic signed [CW-1:0] in_cx, in_cy;
      longint inc;
      bit fin;
      in_cx = data[CW-1:0];
      in_cy = data[2*CW-1:CW];
      if (kind == KIND_START) begin
        cx = longint'(in_cx);
        cy = longint'(in_cy);
        ra = longint'(data[2*CW +: RW]);
        rb = longint'(data[2*CW+RW +: RW]);
        off_x = 0;
        off_y = rb;
        dec = ra * ra * (1 - 2 * rb) + rb * rb;
        starts++;
        if (ra == 0 && rb == 0) begin
          phase = DRAW_DONE;
          return make_point_set(1'b1, 1'b1);
        end
        phase = DRAW_REGION1;
        return make_point_set(1'b1, 1'b0);
      end
      case (phase)
        DRAW_REGION1: begin
          if (under_bound(off_x)) begin
            inc = 2 * rb * rb * (2 * off_x + 3);
            if (dec < 0) begin
              dec += inc;
            end else begin
              dec += inc + 4 * ra * ra * (1 - off_y);
              off_y -= 1;
            end
            off_x += 1;
            return make_point_set(1'b1, 1'b0);
          end
          // Region one is over: restart from (a, 0) for region two.
          off_x = ra;
          off_y = 0;
          dec = rb * rb * (1 - 2 * ra) + ra * ra;
          if (under_bound(off_x)) begin
            phase = DRAW_DONE;
            return make_point_set(1'b1, 1'b1);
          end
          phase = DRAW_REGION2;
          return make_point_set(1'b1, 1'b0);
        end
        DRAW_REGION2: begin
          inc = 2 * ra * ra * (2 * off_y + 3);
          if (dec < 0) begin
            dec += inc;
          end else begin
            dec += inc + 4 * rb * rb * (1 - off_x);
            off_x -= 1;
          end
          off_y += 1;
          fin = under_bound(off_x);
          if (fin) phase = DRAW_DONE;
          return make_point_set(1'b1, fin);
        end
        default: return make_point_set(1'b0, 1'b0);
      endcase
    endfunction

    function void note_item(logic kind, logic [DW-1:0] data);
      accepted++;
      pending_sets.push_back(predict_point_set(kind, data));
    endfunction

    function void check_point_set(logic [OUT_W-1:0] coords, logic valid, logic last);
      point_set_t want;
      if (pending_sets.size() == 0) begin
        flag($sformatf("point set with nothing pending: data %h valid %b last %b",
                       coords, valid, last));
        return;
      end
      want = pending_sets.pop_front();
      checked++;
      if (want.last) completed++;
      if (!want.valid) empties++;
      for (int i = 0; i < 8; i++) begin
        if (coords[i*CW1 +: CW1] !== want.coords[i*CW1 +: CW1])
          flag($sformatf("set %0d pt%0d_%s expected %0d got %0d", checked, i / 2,
                         (i % 2) ? "y" : "x", $signed(want.coords[i*CW1 +: CW1]),
                         $signed(coords[i*CW1 +: CW1])));
      end
      if (valid !== want.valid)
        flag($sformatf("set %0d points_valid expected %b got %b", checked, want.valid, valid));
      if (last !== want.last)
        flag($sformatf("set %0d last expected %b got %b", checked, want.last, last));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic s_valid;
  logic s_ready;
  logic [DW-1:0] s_data;
  logic s_user;
  logic m_valid;
  logic m_ready;
  logic [OUT_W-1:0] m_data;
  logic m_user;
  logic m_last;

  ellipse_tracker tracker;
  int items_sent;
  int burst_left;
  int cycles;

  ellipse_bresenham_raster_core DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  // Every point set taken from the core is checked against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) tracker.check_point_set(m_data, m_user, m_last);
  end

  // Receiver: changes its stall pattern every stretch, and once holds off for long.
  initial begin : receiver
    int mode;
    int stretch;
    int tick;
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    tick = 0;
    mode = 0;
    stretch = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      tick++;
      if (!hold_done && tracker.accepted >= 250) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (stretch == 0) begin
        mode = $urandom_range(0, 3);
        stretch = $urandom_range(20, 200);
      end
      stretch--;
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        case (mode)
          0: m_ready <= 1'b1;
          1: m_ready <= 1'($urandom_range(0, 1));
          2: m_ready <= (tick % 7) < 3;
          default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [DW-1:0] pack_fields(logic [CW-1:0] cx, logic [CW-1:0] cy,
                                                logic [RW-1:0] a, logic [RW-1:0] b);
    logic [DW-1:0] d;
    d = '0;
    d[2*CW+2*RW-1:0] = {b, a, cy, cx};
    return d;
  endfunction

  // Offers one item, holds it until taken, then maybe opens a gap between bursts.
  // Called just after a falling edge and returns just after one.
  task automatic drive_item(logic kind, logic [DW-1:0] data);
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= data;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    tracker.note_item(kind, data);
    items_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(100, 200);
      else burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic send_start(logic [CW-1:0] cx, logic [CW-1:0] cy,
                            logic [RW-1:0] a, logic [RW-1:0] b);
    drive_item(KIND_START, pack_fields(cx, cy, a, b));
  endtask

  // Step items carry random junk in the fields the core must ignore.
  task automatic send_step();
    drive_item(KIND_STEP, pack_fields(CW'($urandom), CW'($urandom),
                                      RW'($urandom), RW'($urandom)));
  endtask

  task automatic step_until_done(int cap);
    int n;
    n = 0;
    while (tracker.phase != DRAW_DONE && n < cap) begin
      send_step();
      n++;
    end
  endtask

  // Stimulus: directed corners first, then random ellipses.
  initial begin : stimulus
    int goal;
    int sel;
    int cap;
    logic [RW-1:0] a, b;
    tracker = new();
    items_sent = 0;
    cycles = 0;
    burst_left = $urandom_range(1, 30);
    rst_n = 1'b0;
    s_valid = 1'b0;
    s_user = KIND_START;
    s_data = '0;
    m_ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // A step straight after reset draws nothing.
    send_step();
    // Smallest ellipse at extreme centres, then a step past its end.
    send_start(CW'(2047), CW'(-2048), RW'(1), RW'(1));
    step_until_done(10);
    send_step();
    // Both radii zero: a single centre point set that is also the last.
    send_start(CW'(-2048), CW'(2047), RW'(0), RW'(0));
    send_step();
    // Flat ellipse: y goes negative and region two ends at once.
    send_start(12'h555, 12'haaa, RW'(3), RW'(0));
    step_until_done(12);
    // Zero horizontal radius.
    send_start(CW'(100), CW'(-100), RW'(0), RW'(3));
    step_until_done(6);
    // Largest radii, abandoned by a new start mid-drawing.
    send_start(CW'(-1), CW'(0), RW'(1023), RW'(1023));
    send_step();
    send_step();
    send_start(CW'(0), CW'(-1), RW'(1023), RW'(1));
    send_step();
    send_step();

    // Random ellipses, mostly small and drawn to the end, some cut short.
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      sel = $urandom_range(0, 99);
      cap = 100000;
      if (sel < 5) begin
        a = RW'($urandom_range(0, 6));
        b = RW'($urandom_range(0, 6));
        if ($urandom_range(0, 1)) a = '0;
        else b = '0;
      end else if (sel < 75) begin
        a = RW'($urandom_range(1, 15));
        b = RW'($urandom_range(1, 15));
      end else if (sel < 85) begin
        a = RW'($urandom_range(16, 60));
        b = RW'($urandom_range(16, 60));
      end else begin
        a = RW'($urandom_range(1, 1023));
        b = RW'($urandom_range(1, 1023));
        cap = $urandom_range(1, 30);
      end
      if ($urandom_range(0, 9) == 0) cap = $urandom_range(0, 5);
      send_start(CW'($urandom), CW'($urandom), a, b);
      step_until_done(cap);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_step();
    end
    s_valid <= 1'b0;

    // Drain what is owed, then watch a while for anything extra.
    while (tracker.pending_sets.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.pending_sets.size() != 0)
      tracker.flag($sformatf("%0d point sets never arrived", tracker.pending_sets.size()));

    $display("tb: %0d items taken, %0d ellipses started, %0d drawn to their last point set",
             tracker.accepted, tracker.starts, tracker.completed);
    $display("tb: %0d point sets checked, %0d of them empty, %0d mismatches",
             tracker.checked, tracker.empties, tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
